// ===== sv/dcr_pkg.sv =====
// Shared constants for the display controller register block.
// Bus address map, command codes and tags, field widths.
// No dependencies.
package dcr_pkg;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;

    localparam logic [15:0] DATA_ADDR  = 16'h0080;
    localparam logic [7:0]  SPACE_CHAR = 8'h20;

    // command code fields
    localparam logic [7:0] TAG_MASK = 8'hE0;
    localparam logic [7:0] ARG_MASK = 8'h1F;

    // self-test codes
    localparam logic [7:0] CMD_TEST_0 = 8'h00;
    localparam logic [7:0] CMD_TEST_1 = 8'h01;
    localparam logic [7:0] CMD_TEST_2 = 8'h02;
    localparam logic [7:0] CMD_TEST_4 = 8'h04;
    localparam logic [7:0] CMD_TEST_8 = 8'h08;

    localparam logic [7:0] CMD_DEV_RESET = 8'hFF;
    localparam logic [7:0] CMD_FLASH_OFF = 8'h80;

    localparam logic [7:0] TAG_SET_POS   = 8'h20;
    localparam logic [7:0] TAG_LAMPS     = 8'h40;
    localparam logic [7:0] TAG_FLASH_ON  = 8'h60;
    localparam logic [7:0] TAG_CLEAR     = 8'hC0;
    localparam logic [7:0] TAG_SCANS     = 8'hE0;

    // request kinds carried on s_tuser
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

endpackage

// ===== sv/display_controller_registers.sv =====
// Display controller register block: character buffer, cursor, flash,
// blank scans and annunciator state behind a data and a control address.
// Depends on dcr_pkg.
//
// Usage: one transaction on the s_ channel is one bus access. s_tuser
// selects a bus write (0) or a read of one stored character (1). A write
// to address 0x0080 stores a character at the cursor; any other address
// is a command. Every access yields exactly one m_ transaction with the
// status byte, the character read (zero on writes) and the state as it
// stands after the access.
// m_tvalid rises in the cycle after acceptance; one access per cycle
// is sustained while the receiver takes each result, since state update
// and result register load happen in the same clock edge as acceptance.
// Reset (aresetn low) fills the buffer with spaces and clears cursor,
// flash, scans, lamps and status at once; the block accepts as soon as
// aresetn is high. When the receiver stalls, the result holds in the output
// register and s_tready drops until it is taken.
module display_controller_registers #(
    parameter int DISPLAY_LEN        = 32,
    parameter int CONTROL_STATUS_BIT = 0
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [15:0] address, [23:16] data, [28:24] char_index, [31:29] zero
    input  logic [dcr_pkg::IN_TDATA_W-1:0]     s_tdata,
    // [0] req_type
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] status, [15:8] char_out, [21:16] cursor, [22] flash_on,
    // [27:23] flash_at, [32:28] blank_scans, [40:33] lamps, [47:41] zero
    output logic [dcr_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import dcr_pkg::*;

    localparam int         IDX_W     = (DISPLAY_LEN > 1) ? $clog2(DISPLAY_LEN) : 1;
    localparam logic [5:0] LEN6      = 6'(DISPLAY_LEN);
    localparam logic [7:0] CTRL_MASK = 8'(1 << CONTROL_STATUS_BIT);

    logic [7:0] store_reg [DISPLAY_LEN];
    logic [5:0] write_pos_reg, write_pos_next;
    logic       flash_mode_reg, flash_mode_next;
    logic [4:0] flash_pos_reg, flash_pos_next;
    logic       ctrl_bit_reg, ctrl_bit_next;
    logic [4:0] scan_count_reg, scan_count_next;
    logic [7:0] lamps_reg, lamps_next;
    logic [7:0] char_out_next;

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic        accept;
    logic [15:0] in_addr;
    logic [7:0]  in_data;
    logic [4:0]  in_idx;
    logic [7:0]  tag;
    logic        is_test;
    logic        store_write;
    logic        store_clear;
    logic [7:0]  status_next;

    assign s_tready = aresetn && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign in_addr = s_tdata[15:0];
    assign in_data = s_tdata[23:16];
    assign in_idx  = s_tdata[28:24];
    assign tag     = in_data & TAG_MASK;
    assign is_test = (in_data == CMD_TEST_0) || (in_data == CMD_TEST_1) ||
                     (in_data == CMD_TEST_2) || (in_data == CMD_TEST_4) ||
                     (in_data == CMD_TEST_8);

    always_comb begin
        write_pos_next  = write_pos_reg;
        flash_mode_next = flash_mode_reg;
        flash_pos_next  = flash_pos_reg;
        ctrl_bit_next   = ctrl_bit_reg;
        scan_count_next = scan_count_reg;
        lamps_next      = lamps_reg;
        store_write     = 1'b0;
        store_clear     = 1'b0;
        char_out_next   = 8'h00;

        if (s_tuser == REQ_READ) begin
            if (6'(in_idx) < LEN6) begin
                char_out_next = store_reg[in_idx[IDX_W-1:0]];
            end
        end else if (in_addr == DATA_ADDR) begin
            if (write_pos_reg < LEN6) begin
                store_write    = 1'b1;
                write_pos_next = write_pos_reg + 6'd1;
                ctrl_bit_next  = 1'b0;
            end else begin
                ctrl_bit_next = 1'b1;
            end
        end else begin
            // first matching code wins; device reset precedes the scans tag
            if (is_test) begin
                ctrl_bit_next = 1'b1;
            end else if (in_data == CMD_DEV_RESET) begin
                flash_mode_next = 1'b0;
                flash_pos_next  = 5'd0;
                scan_count_next = 5'd0;
                lamps_next      = 8'h00;
                write_pos_next  = 6'd0;
                store_clear     = 1'b1;
            end else if (tag == TAG_SET_POS) begin
                write_pos_next = 6'(in_data & ARG_MASK);
            end else if (tag == TAG_LAMPS) begin
                lamps_next = in_data;
            end else if (tag == TAG_FLASH_ON) begin
                flash_pos_next  = 5'(in_data & ARG_MASK);
                flash_mode_next = 1'b1;
            end else if (in_data == CMD_FLASH_OFF) begin
                flash_mode_next = 1'b0;
            end else if (tag == TAG_CLEAR) begin
                write_pos_next = 6'd0;
                store_clear    = 1'b1;
            end else if (tag == TAG_SCANS) begin
                scan_count_next = 5'(in_data & ARG_MASK);
            end
            ctrl_bit_next = 1'b1;
        end
    end

    assign status_next   = ctrl_bit_next ? CTRL_MASK : 8'h00;
    assign out_data_next = {7'd0, lamps_next, scan_count_next, flash_pos_next,
                            flash_mode_next, write_pos_next, char_out_next,
                            status_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_pos_reg  <= 6'd0;
            flash_mode_reg <= 1'b0;
            flash_pos_reg  <= 5'd0;
            ctrl_bit_reg   <= 1'b0;
            scan_count_reg <= 5'd0;
            lamps_reg      <= 8'h00;
            out_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                write_pos_reg  <= write_pos_next;
                flash_mode_reg <= flash_mode_next;
                flash_pos_reg  <= flash_pos_next;
                ctrl_bit_reg   <= ctrl_bit_next;
                scan_count_reg <= scan_count_next;
                lamps_reg      <= lamps_next;
                out_valid_reg  <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= out_data_next;
        end
    end

    // flop register file: the whole buffer clears at once on an accepted clear
    always_ff @(posedge aclk) begin
        for (int i = 0; i < DISPLAY_LEN; i++) begin
            if (!aresetn) begin
                store_reg[i] <= SPACE_CHAR;
            end else if (accept && store_clear) begin
                store_reg[i] <= SPACE_CHAR;
            end else if (accept && store_write &&
                         write_pos_reg[IDX_W-1:0] == IDX_W'(i)) begin
                store_reg[i] <= in_data;
            end
        end
    end

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        write_pos_reg <= 6'd32)
        else $error("cursor beyond buffer-full value");

    a_read_no_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == REQ_READ) |=>
            ($stable(write_pos_reg) && $stable(ctrl_bit_reg) &&
             $stable(lamps_reg) && $stable(flash_mode_reg)))
        else $error("read transaction changed state");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid)
        else $error("accepted transaction produced no result");

    a_write_char_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == REQ_WRITE) |=> (m_tdata[15:8] == 8'h00))
        else $error("char_out nonzero on write result");

endmodule
